### design/bic3_pkg.sv
// shared types, constants and coefficient helpers for the binary 3x3 convolver
package bic3_pkg;

  // coefficient and result formats (signed Q6.4 taps, exact window sum)
  localparam int COEFF_W   = 10;
  localparam int ROW_W     = 3 * COEFF_W;
  localparam int SUM_W     = 14;
  localparam int POS_W     = 3;
  localparam int WIN_W     = 9;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOTTOM = 2'd2;

  // coefficient reset values: top row -1, middle 0, bottom +1
  localparam logic [ROW_W-1:0] COEFF_TOP_RESET    = 30'h3F0F_C3F0;
  localparam logic [ROW_W-1:0] COEFF_MIDDLE_RESET = 30'h0000_0000;
  localparam logic [ROW_W-1:0] COEFF_BOTTOM_RESET = 30'h0100_4010;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one complete window as handed from front to back
  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } win_item_t;

  // queue handshake toward the back end
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;

  // sign-extended coefficient of column kc from one packed row register
  function automatic logic signed [SUM_W-1:0] coeff_at(input logic [ROW_W-1:0] row_v,
                                                       input int kc);
    logic [COEFF_W-1:0] raw;
    raw = row_v[(2 - kc) * COEFF_W +: COEFF_W];
    return {{(SUM_W - COEFF_W){raw[COEFF_W-1]}}, raw};
  endfunction

endpackage

### design/bic3_front.sv
// front end: pixel intake, line store, sliding window and position tracking
module bic3_front #(
  parameter int IMAGE_WIDTH  = 8,
  parameter int IMAGE_HEIGHT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_pixel_bit,
  input  logic                q_ready,
  output logic                in_ready,
  output logic                push,
  output bic3_pkg::win_item_t push_item
);
  import bic3_pkg::*;

  localparam int CW = $clog2(IMAGE_WIDTH);
  localparam int RW = $clog2(IMAGE_HEIGHT);
  localparam logic [CW-1:0] COL_LAST = CW'(IMAGE_WIDTH - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(IMAGE_HEIGHT - 1);
  localparam logic [CW-1:0] COL_TWO  = CW'(2);
  localparam logic [RW-1:0] ROW_TWO  = RW'(2);

  logic [1:0]       line_mem [IMAGE_WIDTH];
  logic [1:0]       held_r;
  logic [CW-1:0]    col_r, col_nxt, rd_addr;
  logic [RW-1:0]    row_r, row_nxt;
  logic [WIN_W-1:0] window_r, window_nxt;
  logic             accept;
  logic [CW-1:0]    col_rel;
  logic [RW-1:0]    row_rel;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  // next position in raster order
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_r == COL_LAST) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_LAST) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // shift window left, new column enters on the right
  always_comb begin
    window_nxt = window_r;
    if (accept) begin
      window_nxt = {in_pixel_bit, window_r[8:7], held_r[0], window_r[5:4],
                    held_r[1], window_r[2:1]};
    end
  end

  // line store: write current column, prefetch the column of the next pixel
  assign rd_addr = accept ? col_nxt : col_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_r] <= {held_r[0], in_pixel_bit};
    end
    held_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      window_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      window_r <= window_nxt;
    end
  end

  // emit once the window is complete
  assign col_rel = col_r - COL_TWO;
  assign row_rel = row_r - ROW_TWO;
  assign push    = accept && (col_r >= COL_TWO) && (row_r >= ROW_TWO);

  always_comb begin
    push_item.window = window_nxt;
    push_item.row    = POS_W'(row_rel);
    push_item.col    = POS_W'(col_rel);
    push_item.last   = (col_r == COL_LAST) && (row_r == ROW_LAST);
  end

endmodule

### design/bic3_queue.sv
// short queue of complete windows between front and back
module bic3_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bic3_pkg::win_item_t push_item,
  output logic                q_ready,
  output bic3_pkg::q_ctrl_t   ctrl_out,
  input  logic                pop_req,
  output bic3_pkg::win_item_t pop_item
);
  import bic3_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  win_item_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic            pop;

  assign q_ready        = (count_r != NW'(QUEUE_DEPTH));
  assign ctrl_out.valid = (count_r != '0);
  assign pop            = pop_req && ctrl_out.valid;
  assign ctrl_out.pop   = pop;
  assign pop_item       = slot_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### design/bic3_back.sv
// back end: coefficient registers, window sum and output register
module bic3_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bic3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bic3_pkg::ROW_W-1:0]         cfg_data,
  input  bic3_pkg::q_ctrl_t                  ctrl_in,
  input  bic3_pkg::win_item_t                pop_item,
  output logic                               pop_req,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bic3_pkg::SUM_W-1:0]  out_conv_value,
  output logic [bic3_pkg::POS_W-1:0]         out_row,
  output logic [bic3_pkg::POS_W-1:0]         out_col,
  output logic                               out_frame_last
);
  import bic3_pkg::*;

  logic [ROW_W-1:0]        coeff_r [3];
  logic signed [SUM_W-1:0] sum;
  logic                    valid_r, valid_nxt;
  logic signed [SUM_W-1:0] value_r;
  logic [POS_W-1:0]        row_r, col_r;
  logic                    last_r;

  // coefficient register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r[0] <= COEFF_TOP_RESET;
      coeff_r[1] <= COEFF_MIDDLE_RESET;
      coeff_r[2] <= COEFF_BOTTOM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COEFF_TOP:    coeff_r[0] <= cfg_data;
        REG_COEFF_MIDDLE: coeff_r[1] <= cfg_data;
        REG_COEFF_BOTTOM: coeff_r[2] <= cfg_data;
        default:          ;
      endcase
    end
  end

  // select taps under set window bits and add them up
  always_comb begin
    sum = '0;
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        if (pop_item.window[3 * kr + kc]) begin
          sum = sum + coeff_at(coeff_r[kr], kc);
        end
      end
    end
  end

  // take the next window whenever the output register is free or drains
  assign pop_req = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ctrl_in.pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.pop) begin
      value_r <= sum;
      row_r   <= pop_item.row;
      col_r   <= pop_item.col;
      last_r  <= pop_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_conv_value = value_r;
  assign out_row        = row_r;
  assign out_col        = col_r;
  assign out_frame_last = last_r;

endmodule

### design/binary_image_conv3x3_top.sv
// top level of the streaming 3x3 convolver for binary images
// an accepted pixel's window is written into a queue slot, then its sum into the output register
// throughput: 1 pixel per cycle while the queue is not full, set by the line store's single prefetched read port
// a result appears for each pixel at row and column 2 or more; a 2-entry queue
// decouples the window front end from the sum and output register
// reset (synchronous, active low) clears position, window, queue and output valid
// and restores the coefficients; the line store is not cleared
module binary_image_conv3x3_top #(
  parameter int IMAGE_WIDTH  = 8,
  parameter int IMAGE_HEIGHT = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_pixel_bit,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bic3_pkg::SUM_W-1:0]  out_conv_value,
  output logic [bic3_pkg::POS_W-1:0]         out_row,
  output logic [bic3_pkg::POS_W-1:0]         out_col,
  output logic                               out_frame_last,
  input  logic                               cfg_wr_en,
  input  logic [bic3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bic3_pkg::ROW_W-1:0]         cfg_data
);
  import bic3_pkg::*;

  logic      q_ready;
  logic      push;
  win_item_t push_item;
  win_item_t pop_item;
  q_ctrl_t   q_ctrl;
  logic      pop_req;

  // window front end
  bic3_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_pixel_bit (in_pixel_bit),
    .q_ready      (q_ready),
    .in_ready     (in_ready),
    .push         (push),
    .push_item    (push_item)
  );

  // decoupling queue
  bic3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .ctrl_out  (q_ctrl),
    .pop_req   (pop_req),
    .pop_item  (pop_item)
  );

  // sum and output stage
  bic3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .ctrl_in        (q_ctrl),
    .pop_item       (pop_item),
    .pop_req        (pop_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_conv_value (out_conv_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

  // a full queue only happens while a result sits stalled at the output
  a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("queue full without a stalled result");

  // the final result of a frame sits at the last window position
  a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_last) |->
      (out_col == POS_W'(IMAGE_WIDTH - 3)) && (out_row == POS_W'(IMAGE_HEIGHT - 3)))
    else $error("frame end flagged away from the last window");

  // no item leaves the queue while it is empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctrl.pop |-> q_ctrl.valid)
    else $error("queue popped while empty");

endmodule

### bench/tb.sv
// self-checking bench for the binary 3x3 convolver: scoreboard class, stalled random stimulus
`timescale 1ns / 100ps

module tb;
  import bic3_pkg::*;

  localparam int IMAGE_W     = 8;
  localparam int IMAGE_H     = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 125;

  // the index past the last coefficient row, which the block ignores
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // rows of coefficients used as extremes and fixed kernels
  localparam logic [ROW_W-1:0] ROW_MAX   = {3{10'h1FF}};
  localparam logic [ROW_W-1:0] ROW_MIN   = {3{10'h200}};
  localparam logic [ROW_W-1:0] ROW_ZERO  = '0;
  localparam logic [ROW_W-1:0] GAUSS_OUT = {10'd1, 10'd2, 10'd1};
  localparam logic [ROW_W-1:0] GAUSS_MID = {10'd2, 10'd4, 10'd2};

  // tracks the window state and holds the expected window sums
  class conv_tracker;
    typedef struct {
      logic signed [SUM_W-1:0] sum;
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic                    last;
    } window_sum_t;

    window_sum_t      pending_sums[$];
    logic [1:0]       history[IMAGE_W];
    logic [WIN_W-1:0] win;
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [ROW_W-1:0] coeff[3];
    int               errors;

    function new();
      coeff[0] = COEFF_TOP_RESET;
      coeff[1] = COEFF_MIDDLE_RESET;
      coeff[2] = COEFF_BOTTOM_RESET;
      foreach (history[i]) history[i] = 2'b00;
      win     = '0;
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
    endfunction

    function void set_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
      case (idx)
        REG_COEFF_TOP:    coeff[0] = val;
        REG_COEFF_MIDDLE: coeff[1] = val;
        REG_COEFF_BOTTOM: coeff[2] = val;
        default: ;
      endcase
    endfunction

    // signed tap of kernel row kr, column kc (left column in the high bits)
    function logic signed [SUM_W-1:0] tap(int kr, int kc);
      logic signed [COEFF_W-1:0] raw;
      logic signed [SUM_W-1:0]   ext;
      raw = coeff[kr][(2 - kc) * COEFF_W +: COEFF_W];
      ext = raw;
      return ext;
    endfunction

    // shift one accepted pixel into the window and queue its sum, if any
    function void note_pixel(logic px);
      logic                    older;
      logic                    newer;
      logic                    last;
      int unsigned             col;
      int unsigned             row;
      window_sum_t             item;
      logic signed [SUM_W-1:0] acc;
      col   = col_pos;
      row   = row_pos;
      older = history[col][1];
      newer = history[col][0];
      history[col] = {newer, px};
      win  = {px, win[8:7], newer, win[5:4], older, win[2:1]};
      last = (col == IMAGE_W - 1) && (row == IMAGE_H - 1);
      if (col == IMAGE_W - 1) begin
        col_pos = 0;
        row_pos = (row == IMAGE_H - 1) ? 0 : row + 1;
      end else begin
        col_pos = col + 1;
      end
      if (row >= 2 && col >= 2) begin
        acc = '0;
        for (int kr = 0; kr < 3; kr++)
          for (int kc = 0; kc < 3; kc++)
            if (win[3 * kr + kc]) acc += tap(kr, kc);
        item.sum  = acc;
        item.row  = POS_W'(row - 2);
        item.col  = POS_W'(col - 2);
        item.last = last;
        pending_sums.push_back(item);
      end
    endfunction

    // compare one delivered result with the oldest expected sum
    function void check_window(logic signed [SUM_W-1:0] sum, logic [POS_W-1:0] row,
                               logic [POS_W-1:0] col, logic last);
      window_sum_t item;
      if (pending_sums.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: unexpected result sum=%0d row=%0d col=%0d last=%0b",
                   sum, row, col, last);
        return;
      end
      item = pending_sums.pop_front();
      if (item.sum !== sum || item.row !== row || item.col !== col || item.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected sum=%0d row=%0d col=%0d last=%0b, got %0d %0d %0d %0b",
                   item.sum, item.row, item.col, item.last, sum, row, col, last);
      end
    endfunction
  endclass

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_pixel_bit = 1'b0;
  logic                    out_ready    = 1'b0;
  logic                    cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index    = REG_COEFF_TOP;
  logic [ROW_W-1:0]        cfg_data     = '0;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [SUM_W-1:0] out_conv_value;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic                    out_frame_last;

  int send_idle   = 35;
  int recv_idle   = 59;
  int quiet_count = 0;

  conv_tracker tracker = new();

  binary_image_conv3x3_top #(
    .IMAGE_WIDTH  (IMAGE_W),
    .IMAGE_HEIGHT (IMAGE_H)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_bit   (in_pixel_bit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_conv_value (out_conv_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // watch both channels, feed the tracker and guard against a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_pixel(in_pixel_bit);
      if (out_valid && out_ready)
        tracker.check_window(out_conv_value, out_row, out_col, out_frame_last);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
        if (quiet_count >= STALL_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // offer one pixel, with an optional gap first, and wait until it is taken
  task automatic send_pixel(input logic px);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid     <= 1'b1;
    in_pixel_bit <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait until every expected sum has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all three coefficient rows plus the ignored index
  task automatic program_coeffs(input logic [ROW_W-1:0] top, input logic [ROW_W-1:0] mid,
                                input logic [ROW_W-1:0] bot);
    logic [CFG_IDX_W-1:0] idx_list[4];
    logic [ROW_W-1:0]     val_list[4];
    idx_list = '{REG_UNUSED, REG_COEFF_TOP, REG_COEFF_MIDDLE, REG_COEFF_BOTTOM};
    val_list = '{ROW_W'($urandom), top, mid, bot};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      @(posedge clk);
      tracker.set_row(idx_list[i], val_list[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int density;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // largest positive sums over rows 0 to 2, then most negative at the row end
    program_coeffs(ROW_MAX, ROW_MAX, ROW_MAX);
    for (int i = 0; i < 20; i++) send_pixel(1'b1);
    drain();
    program_coeffs(ROW_MIN, ROW_MIN, ROW_MIN);
    for (int i = 0; i < 4; i++) send_pixel(1'b1);
    drain();

    // random phases over kernels and idling modes
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin send_idle = 35; recv_idle = 59; end
        1: begin send_idle = 59; recv_idle = 35; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (p)
        0: program_coeffs(ROW_W'($urandom), ROW_W'($urandom), ROW_W'($urandom));
        1: program_coeffs(ROW_ZERO, ROW_ZERO, ROW_ZERO);
        2: program_coeffs(COEFF_TOP_RESET, COEFF_MIDDLE_RESET, COEFF_BOTTOM_RESET);
        3: program_coeffs(ROW_MAX, ROW_MIN, ROW_W'($urandom));
        4: program_coeffs(ROW_W'($urandom), ROW_W'($urandom), ROW_W'($urandom));
        default: program_coeffs(GAUSS_OUT, GAUSS_MID, GAUSS_OUT);
      endcase
      density = $urandom_range(95, 5);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_pixel($urandom_range(99) < density);
      drain();
    end

    if (tracker.errors == 0 && tracker.pending_sums.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
